FILE: sv/rnpa_pkg.sv
// ----------------------------------------------------------------------------
// rnpa_pkg
// shared types and constants of the ratio normalized profile averager
// ----------------------------------------------------------------------------
package rnpa_pkg;

  localparam int SMP_W  = 16;
  localparam int RB_W   = 10;
  localparam int BIN_W  = 11;
  localparam int CNT_W  = 24;
  localparam int AVG_W  = 48;
  localparam int SUM_W  = 64;
  localparam int CFG_W  = 24;
  localparam int CFGA_W = 2;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 31;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 80;

  localparam logic [CFGA_W-1:0] CFG_BINS_IN_USE = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_REF_BIN     = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_SHOTS       = 2'd2;

  localparam logic [BIN_W-1:0] BINS_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] SHOTS_RST = 24'd1000;

  typedef struct packed {
    logic st_we;
    logic st_re;
    logic acc_re;
    logic acc_we;
    logic clr_we;
    logic ref_load;
    logic ref_zero;
    logic mul;
    logic div_ratio;
    logic div_avg;
    logic load_out;
    logic out_read;
    logic out_none;
    logic done_flag;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic cnt_zero;
    logic div_busy;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/ratio_normalized_profile_averager.sv
// ----------------------------------------------------------------------------
// ratio_normalized_profile_averager
// accumulates per-bin anti-stokes/stokes ratios over shots, two swapping banks
// ----------------------------------------------------------------------------
// A sample word inside a shot is stored and gets its result handoff. The
// sample that ends a shot starts a walk over every bin of the shot: the
// reference pair is read and loaded, then each bin is read, multiplied and
// checked, and a bin whose denominator is nonzero also passes through the
// shared one-bit-per-cycle divider and a write-back. When the shot ends a
// profile, the new write bank is cleared one entry a cycle and the result
// carries profile_done. A read word waits on the same divider before its
// result handoff; a bin with no valid ratio skips the divider. After reset
// both banks are cleared, and meanwhile no word is accepted; configuration
// writes are taken anytime.
module ratio_normalized_profile_averager
  import rnpa_pkg::*;
#(
  parameter int MAX_BINS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // antistokes_sample, stokes_sample, read_bin
  input  logic              s_tuser,   // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // bin_average, bin_count, no_valid_ratio
  output logic              m_tuser    // profile_done
);

  localparam int AW = $clog2(MAX_BINS);

  cmd_t             cmd;
  sts_t             sts;
  logic [AW-1:0]    st_addr;
  logic [AW:0]      acc_addr;
  logic [AVG_W-1:0] bin_average;
  logic [CNT_W-1:0] bin_count;
  logic             no_valid_ratio;

  rnpa_ctrl #(.MAX_BINS(MAX_BINS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tuser),
    .read_bin  (s_tdata[41:32]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts),
    .st_addr   (st_addr),
    .acc_addr  (acc_addr)
  );

  rnpa_dp #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .st_addr           (st_addr),
    .acc_addr          (acc_addr),
    .antistokes_sample (s_tdata[15:0]),
    .stokes_sample     (s_tdata[31:16]),
    .profile_done      (m_tuser),
    .bin_average       (bin_average),
    .bin_count         (bin_count),
    .no_valid_ratio    (no_valid_ratio)
  );

  assign m_tdata = {7'd0, no_valid_ratio, bin_count, bin_average};

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while a result is pending");

  a_done_word_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("profile_done word carries read data");

  a_none_zero_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[72]) |-> (m_tdata[71:0] == '0))
    else $error("no_valid_ratio with nonzero average or count");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_ratio || cmd.div_avg) |-> !sts.div_busy)
    else $error("divider started while busy");

endmodule

FILE: sv/rnpa_div.sv
// ----------------------------------------------------------------------------
// rnpa_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rnpa_div
  import rnpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W:0]    rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh   = {rem[DVS_W-1:0], dvd[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

endmodule

FILE: sv/rnpa_dp.sv
// ----------------------------------------------------------------------------
// rnpa_dp
// datapath: shot store, sum and count banks, ratio and average arithmetic
// ----------------------------------------------------------------------------
module rnpa_dp
  import rnpa_pkg::*;
#(
  parameter int MAX_BINS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic [$clog2(MAX_BINS)-1:0]  st_addr,
  input  logic [$clog2(MAX_BINS):0]    acc_addr,
  input  logic [SMP_W-1:0]             antistokes_sample,
  input  logic [SMP_W-1:0]             stokes_sample,
  output logic                         profile_done,
  output logic [AVG_W-1:0]             bin_average,
  output logic [CNT_W-1:0]             bin_count,
  output logic                         no_valid_ratio
);

  localparam int AW        = $clog2(MAX_BINS);
  localparam int ACC_DEPTH = 2 ** (AW + 1);

  logic [2*SMP_W-1:0] st_mem [MAX_BINS];
  logic [SUM_W-1:0]   sum_mem [ACC_DEPTH];
  logic [CNT_W-1:0]   cnt_mem [ACC_DEPTH];

  logic [2*SMP_W-1:0]       st_q;
  logic [SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SMP_W-1:0]  ref_as;
  logic signed [SMP_W-1:0]  ref_s;
  logic signed [2*SMP_W-1:0] num;
  logic signed [2*SMP_W-1:0] den;
  logic [2*SMP_W-1:0]       mag_num;
  logic [2*SMP_W-1:0]       mag_den;
  logic                     rneg;
  logic [DVD_W-1:0]         dvd;
  logic [DVS_W-1:0]         dvs;
  logic [DVD_W-1:0]         quo;
  logic [SUM_W-1:0]         ratio;
  logic [SUM_W:0]           sum_ext;
  logic [SUM_W-1:0]         sum_new;
  logic [CNT_W-1:0]         cnt_new;
  logic [SUM_W-1:0]         mag_sum;
  logic [DVD_W-1:0]         qclamp;
  logic [AVG_W-1:0]         avg;

  always_ff @(posedge clk) begin
    if (cmd.st_we) st_mem[st_addr] <= {antistokes_sample, stokes_sample};
    if (cmd.st_re) st_q <= st_mem[st_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      sum_mem[acc_addr] <= '0;
      cnt_mem[acc_addr] <= '0;
    end else if (cmd.acc_we) begin
      sum_mem[acc_addr] <= sum_new;
      cnt_mem[acc_addr] <= cnt_new;
    end
    if (cmd.acc_re) begin
      sum_q <= sum_mem[acc_addr];
      cnt_q <= cnt_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_load) begin
      ref_as <= cmd.ref_zero ? '0 : $signed(st_q[2*SMP_W-1:SMP_W]);
      ref_s  <= cmd.ref_zero ? '0 : $signed(st_q[SMP_W-1:0]);
    end
    if (cmd.mul) begin
      num <= $signed(st_q[2*SMP_W-1:SMP_W]) * ref_s;
      den <= $signed(st_q[SMP_W-1:0]) * ref_as;
    end
  end

  assign mag_num = num[2*SMP_W-1] ? 32'(-num) : 32'(num);
  assign mag_den = den[2*SMP_W-1] ? 32'(-den) : 32'(den);
  assign rneg    = num[2*SMP_W-1] ^ den[2*SMP_W-1];
  assign mag_sum = sum_q[SUM_W-1] ? -sum_q : sum_q;

  always_comb begin
    if (cmd.div_avg) begin
      dvd = mag_sum;
      dvs = DVS_W'(cnt_q);
    end else begin
      dvd = {17'd0, mag_num[DVS_W-1:0], 16'd0};
      dvs = mag_den[DVS_W-1:0];
    end
  end

  rnpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_ratio | cmd.div_avg),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (sts.div_busy),
    .done     (sts.div_done),
    .quotient (quo)
  );

  // saturating accumulate of the signed ratio
  assign ratio   = rneg ? -quo : quo;
  assign sum_ext = {sum_q[SUM_W-1], sum_q} + {ratio[SUM_W-1], ratio};
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
      sum_new = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_new = sum_ext[SUM_W-1:0];
  end
  assign cnt_new = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

  // average clamp to the 48 bit signed range
  always_comb begin
    if (sum_q[SUM_W-1]) begin
      qclamp = (quo > (DVD_W'(1) << (AVG_W - 1))) ? (DVD_W'(1) << (AVG_W - 1)) : quo;
      avg    = -qclamp[AVG_W-1:0];
    end else begin
      qclamp = (quo > ((DVD_W'(1) << (AVG_W - 1)) - 1'b1)) ?
               ((DVD_W'(1) << (AVG_W - 1)) - 1'b1) : quo;
      avg    = qclamp[AVG_W-1:0];
    end
  end

  assign sts.den_zero = den == '0;
  assign sts.cnt_zero = cnt_q == '0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      profile_done   <= cmd.done_flag;
      bin_average    <= cmd.out_read ? avg : '0;
      bin_count      <= cmd.out_read ? cnt_q : '0;
      no_valid_ratio <= cmd.out_none;
    end
  end

endmodule

FILE: sv/rnpa_ctrl.sv
// ----------------------------------------------------------------------------
// rnpa_ctrl
// controller: registers, bin and shot counters, bin walk and clearing
// ----------------------------------------------------------------------------
module rnpa_ctrl
  import rnpa_pkg::*;
#(
  parameter int MAX_BINS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFGA_W-1:0]            cfg_addr,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [RB_W-1:0]              read_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cmd_t                         cmd,
  input  sts_t                         sts,
  output logic [$clog2(MAX_BINS)-1:0]  st_addr,
  output logic [$clog2(MAX_BINS):0]    acc_addr
);

  localparam int AW = $clog2(MAX_BINS);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REF_RD = 4'd2;
  localparam logic [3:0] S_REF_LD = 4'd3;
  localparam logic [3:0] S_BIN_RD = 4'd4;
  localparam logic [3:0] S_BIN_MU = 4'd5;
  localparam logic [3:0] S_BIN_CK = 4'd6;
  localparam logic [3:0] S_BIN_DV = 4'd7;
  localparam logic [3:0] S_BIN_WR = 4'd8;
  localparam logic [3:0] S_RD_CK  = 4'd9;
  localparam logic [3:0] S_RD_DV  = 4'd10;

  logic [3:0]       state, state_next;
  logic [BIN_W-1:0] bins_in_use;
  logic [RB_W-1:0]  ref_bin;
  logic [CFG_W-1:0] shots_per_profile;
  logic [AW-1:0]    pos, pos_next;
  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    cidx, cidx_next;
  logic             cbank, cbank_next;
  logic             clr_both, clr_both_next;
  logic             pend_done, pend_done_next;
  logic [CFG_W-1:0] shot, shot_next;
  logic             bank, bank_next;
  logic [AW-1:0]    rb, rb_next;
  logic             rb_oob, rb_oob_next;
  logic [AW:0]      nb;
  logic [CFG_W-1:0] spp;
  logic             accept;
  logic             last_pos;
  logic             last_idx;
  logic             last_shot;

  always_comb begin
    if (bins_in_use == '0) nb = (AW+1)'(1);
    else if (32'(bins_in_use) > MAX_BINS) nb = (AW+1)'(MAX_BINS);
    else nb = (AW+1)'(bins_in_use);
  end

  assign spp       = (shots_per_profile == '0) ? CFG_W'(1) : shots_per_profile;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign accept    = in_valid && in_ready;
  assign last_pos  = ({1'b0, pos} + 1'b1) >= nb;
  assign last_idx  = ({1'b0, idx} + 1'b1) >= nb;
  assign last_shot = ({1'b0, shot} + 1'b1) >= {1'b0, spp};

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use       <= BINS_RST;
      ref_bin           <= '0;
      shots_per_profile <= SHOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BINS_IN_USE: bins_in_use       <= cfg_wdata[BIN_W-1:0];
        CFG_REF_BIN:     ref_bin           <= cfg_wdata[RB_W-1:0];
        CFG_SHOTS:       shots_per_profile <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    idx_next       = idx;
    cidx_next      = cidx;
    cbank_next     = cbank;
    clr_both_next  = clr_both;
    pend_done_next = pend_done;
    shot_next      = shot;
    bank_next      = bank;
    rb_next        = rb;
    rb_oob_next    = rb_oob;
    cmd            = '0;
    st_addr        = idx;
    acc_addr       = {bank, idx};
    unique case (state)
      S_CLR: begin
        acc_addr   = {cbank, cidx};
        cmd.clr_we = 1'b1;
        if (32'(cidx) == MAX_BINS - 1) begin
          cidx_next = '0;
          if (clr_both && !cbank) begin
            cbank_next = 1'b1;
          end else begin
            clr_both_next  = 1'b0;
            pend_done_next = 1'b0;
            cmd.load_out   = pend_done;
            cmd.done_flag  = pend_done;
            state_next     = S_IDLE;
          end
        end else begin
          cidx_next = cidx + 1'b1;
        end
      end
      S_IDLE: begin
        st_addr  = pos;
        acc_addr = {~bank, AW'(read_bin)};
        if (accept) begin
          if (!op) begin
            cmd.st_we = 1'b1;
            if (last_pos) begin
              pos_next   = '0;
              state_next = S_REF_RD;
            end else begin
              pos_next     = pos + 1'b1;
              cmd.load_out = 1'b1;
            end
          end else begin
            cmd.acc_re  = 1'b1;
            rb_oob_next = 32'(read_bin) >= MAX_BINS;
            rb_next     = AW'(read_bin);
            state_next  = S_RD_CK;
          end
        end
      end
      S_REF_RD: begin
        st_addr    = AW'(ref_bin);
        cmd.st_re  = 1'b1;
        state_next = S_REF_LD;
      end
      S_REF_LD: begin
        cmd.ref_load = 1'b1;
        cmd.ref_zero = !(32'(ref_bin) < 32'(nb));
        idx_next     = '0;
        state_next   = S_BIN_RD;
      end
      S_BIN_RD: begin
        cmd.st_re  = 1'b1;
        cmd.acc_re = 1'b1;
        state_next = S_BIN_MU;
      end
      S_BIN_MU: begin
        cmd.mul    = 1'b1;
        state_next = S_BIN_CK;
      end
      S_BIN_CK, S_BIN_WR: begin
        if (state == S_BIN_CK && !sts.den_zero) begin
          cmd.div_ratio = 1'b1;
          state_next    = S_BIN_DV;
        end else begin
          cmd.acc_we = (state == S_BIN_WR);
          if (!last_idx) begin
            idx_next   = idx + 1'b1;
            state_next = S_BIN_RD;
          end else if (last_shot) begin
            shot_next      = '0;
            bank_next      = ~bank;
            cbank_next     = ~bank;
            cidx_next      = '0;
            clr_both_next  = 1'b0;
            pend_done_next = 1'b1;
            state_next     = S_CLR;
          end else begin
            shot_next    = shot + 1'b1;
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_BIN_DV: begin
        if (sts.div_done) state_next = S_BIN_WR;
      end
      S_RD_CK: begin
        if (rb_oob || sts.cnt_zero) begin
          cmd.load_out = 1'b1;
          cmd.out_none = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.div_avg = 1'b1;
          state_next  = S_RD_DV;
        end
      end
      S_RD_DV: begin
        acc_addr = {~bank, rb};
        if (sts.div_done) begin
          cmd.load_out = 1'b1;
          cmd.out_read = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      pos       <= '0;
      idx       <= '0;
      cidx      <= '0;
      cbank     <= 1'b0;
      clr_both  <= 1'b1;
      pend_done <= 1'b0;
      shot      <= '0;
      bank      <= 1'b0;
      out_valid <= 1'b0;
      rb        <= '0;
      rb_oob    <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      idx       <= idx_next;
      cidx      <= cidx_next;
      cbank     <= cbank_next;
      clr_both  <= clr_both_next;
      pend_done <= pend_done_next;
      shot      <= shot_next;
      bank      <= bank_next;
      rb        <= rb_next;
      rb_oob    <= rb_oob_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: test/ratio_normalized_profile_averager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ratio_normalized_profile_averager_tb
// Directed table, a full-size shot, then random shot/read traffic with
// random registers. A behavioral copy of the accumulator and the two banks
// predicts untyped result words; results are compared field by field in order.
// ----------------------------------------------------------------------------
module ratio_normalized_profile_averager_tb;
  import rnpa_pkg::*;

  localparam int NBINS = 1024;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [15:0]       as_v;
    logic [15:0]       st_v;
    logic [23:0]       val;
    logic [CFGA_W-1:0] addr;
    logic              typed;
    logic              e_done;
    logic              e_none;
  } row_t;

  typedef struct {
    logic        done;
    logic [47:0] avg;
    logic [23:0] cnt;
    logic        none;
  } res_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_we = 0;
  logic [CFGA_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 0;
  logic              m_tvalid;
  logic              m_tready = 0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;

  ratio_normalized_profile_averager DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  logic [10:0] bins_reg = 11'd1024;
  logic [9:0]  ref_reg = '0;
  logic [23:0] shots_reg = 24'd1000;
  logic [31:0] shot_mem [NBINS];
  longint      sums [2][NBINS];
  int unsigned cnts [2][NBINS];
  int unsigned bin_pos = 0;
  int unsigned shot_cnt = 0;
  bit          bank = 0;

  res_t        expected_q[$];
  int          errors = 0;
  int          words_sent = 0;
  bit          send_gaps = 1;
  bit          recv_gaps = 1;
  bit          hold_req = 0;

  function automatic longint sat_add(longint a, longint b);
    longint r;
    r = a + b;
    if (b > 0 && r < a) r = 64'sh7FFFFFFFFFFFFFFF;
    if (b < 0 && r > a) r = 64'sh8000000000000000;
    return r;
  endfunction

  function automatic void close_shot(int unsigned nb);
    int ras, rs, a, s;
    longint num, den, q;
    ras = 0;
    rs = 0;
    if (ref_reg < nb) begin
      ras = $signed(shot_mem[ref_reg][31:16]);
      rs  = $signed(shot_mem[ref_reg][15:0]);
    end
    for (int i = 0; i < nb; i++) begin
      a = $signed(shot_mem[i][31:16]);
      s = $signed(shot_mem[i][15:0]);
      num = a * rs;
      den = s * ras;
      if (den == 0) continue;
      q = ((num < 0 ? -num : num) << 16) / (den < 0 ? -den : den);
      if ((num < 0) != (den < 0)) q = -q;
      sums[bank][i] = sat_add(sums[bank][i], q);
      if (cnts[bank][i] < 24'hFFFFFF) cnts[bank][i]++;
    end
  endfunction

  function automatic res_t predict_word(logic op, logic [15:0] as_v, logic [15:0] st_v,
                                        logic [9:0] rb);
    res_t r;
    int unsigned nb, pos, spp;
    logic [63:0] mag, q;
    longint sm;
    r = '{1'b0, 48'd0, 24'd0, 1'b0};
    if (op == 1'b0) begin
      nb = bins_reg == 0 ? 1 : (bins_reg > NBINS ? NBINS : bins_reg);
      pos = bin_pos >= NBINS ? NBINS - 1 : bin_pos;
      shot_mem[pos] = {as_v, st_v};
      if (pos + 1 >= nb) begin
        spp = shots_reg == 0 ? 1 : shots_reg;
        close_shot(nb);
        bin_pos = 0;
        if (shot_cnt + 1 >= spp) begin
          shot_cnt = 0;
          bank = ~bank;
          for (int i = 0; i < NBINS; i++) begin
            sums[bank][i] = 0;
            cnts[bank][i] = 0;
          end
          r.done = 1;
        end else begin
          shot_cnt++;
        end
      end else begin
        bin_pos = pos + 1;
      end
    end else if (cnts[~bank][rb] == 0) begin
      r.none = 1;
    end else begin
      sm = sums[~bank][rb];
      mag = sm < 0 ? -sm : sm;
      q = mag / cnts[~bank][rb];
      if (sm < 0) begin
        if (q > 64'h800000000000) q = 64'h800000000000;
        r.avg = 48'(-q);
      end else begin
        if (q > 64'h7FFFFFFFFFFF) q = 64'h7FFFFFFFFFFF;
        r.avg = q[47:0];
      end
      r.cnt = cnts[~bank][rb][23:0];
    end
    return r;
  endfunction

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFGA_W-1:0] a, logic [23:0] v);
    s_tvalid <= 0;
    drain();
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (a)
      CFG_BINS_IN_USE: bins_reg = v[10:0];
      CFG_REF_BIN:     ref_reg = v[9:0];
      CFG_SHOTS:       shots_reg = v;
      default: ;
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic op, logic [15:0] as_v, logic [15:0] st_v, logic [9:0] rb,
                           bit typed, res_t tv);
    int gap;
    res_t r;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {6'd0, rb, st_v, as_v};
    do @(posedge clk); while (!s_tready);
    r = predict_word(op, as_v, st_v, rb);
    expected_q.push_back(typed ? tv : r);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver side
  initial begin
    int n;
    bit held;
    held = 0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        held = 1;
      end
      n = recv_gaps ? $urandom_range(0, 12) : 0;
      if (n > 0) begin
        m_tready <= 0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_tuser !== e.done) begin
          $display("%0t: profile_done exp %b act %b", $time, e.done, m_tuser);
          errors++;
        end
        if (m_tdata[47:0] !== e.avg) begin
          $display("%0t: bin_average exp %h act %h", $time, e.avg, m_tdata[47:0]);
          errors++;
        end
        if (m_tdata[71:48] !== e.cnt) begin
          $display("%0t: bin_count exp %0d act %0d", $time, e.cnt, m_tdata[71:48]);
          errors++;
        end
        if (m_tdata[72] !== e.none) begin
          $display("%0t: no_valid_ratio exp %b act %b", $time, e.none, m_tdata[72]);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  row_t dir_tab[] = '{
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd0,    '0, 1, 0, 1},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd1023, '0, 1, 0, 1},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd2, CFG_BINS_IN_USE, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd0, CFG_REF_BIN,     0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd1, CFG_SHOTS,       0, 0, 0},
    '{ROW_WORD, 0, 16'd100, 16'd50, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'h7FFF, 16'h8000, 24'd0, '0, 1, 1, 0},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd0, '0, 0, 0, 0},
    '{ROW_WORD, 1, 16'hFFFF, 16'hFFFF, 24'd1, '0, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd0, CFG_BINS_IN_USE, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd0, CFG_SHOTS,       0, 0, 0},
    '{ROW_WORD, 0, 16'h8000, 16'h8000, 24'd0, '0, 1, 1, 0},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd0, '0, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd3, CFG_BINS_IN_USE, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd5, CFG_REF_BIN,     0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd2, CFG_SHOTS,       0, 0, 0},
    '{ROW_WORD, 0, 16'd1, 16'd1, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'hFFFF, 16'd2, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd5, 16'd5, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd4, 16'd3, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd9, 16'd8, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd2, 16'd7, 24'd0, '0, 1, 1, 0},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd2, '0, 1, 0, 1},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd1, CFG_REF_BIN,     0, 0, 0},
    '{ROW_WORD, 0, 16'd7, 16'd0, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd0, 16'd9, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'hFFFD, 16'd4, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd3, 16'd3, 24'd0, '0, 0, 0, 0},
    '{ROW_WORD, 0, 16'd2, 16'd2, 24'd0, '0, 0, 0, 0},
    '{ROW_WORD, 0, 16'd1, 16'hFFFF, 24'd0, '0, 0, 0, 0},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd0, '0, 0, 0, 0},
    '{ROW_WORD, 1, 16'h0, 16'h0, 24'd2, '0, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd8, CFG_BINS_IN_USE, 0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd3, CFG_SHOTS,       0, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd0, CFG_REF_BIN,     0, 0, 0},
    '{ROW_WORD, 0, 16'd11, 16'd13, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd12, 16'd14, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd15, 16'd16, 24'd0, '0, 1, 0, 0},
    '{ROW_WORD, 0, 16'd17, 16'd18, 24'd0, '0, 1, 0, 0},
    '{ROW_CFG,  0, 16'h0, 16'h0, 24'd2, CFG_BINS_IN_USE, 0, 0, 0},
    '{ROW_WORD, 0, 16'd19, 16'd20, 24'd0, '0, 1, 0, 0}
  };

  initial begin
    int nb, nitems;
    res_t tv;
    for (int i = 0; i < NBINS; i++) begin
      shot_mem[i] = '0;
      for (int k = 0; k < 2; k++) begin
        sums[k][i] = 0;
        cnts[k][i] = 0;
      end
    end
    repeat (4) @(negedge clk);
    rst <= 0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        tv = '{dir_tab[i].e_done, 48'd0, 24'd0, dir_tab[i].e_none};
        send_word(dir_tab[i].op, dir_tab[i].as_v, dir_tab[i].st_v, dir_tab[i].val[9:0],
                  dir_tab[i].typed, tv);
      end
    end

    // one full-size shot, register extremes
    write_reg(CFG_BINS_IN_USE, 24'd2047);
    write_reg(CFG_REF_BIN, 24'd1023);
    write_reg(CFG_SHOTS, 24'd1);
    send_gaps = 0;
    for (int i = 0; i < NBINS; i++)
      send_word(0, ($urandom_range(0, 7) == 0) ? rand_sample() : 16'd0, rand_sample(),
                10'd0, 0, tv);
    send_gaps = 1;
    for (int i = 0; i < 6; i++) send_word(1, 16'h0, 16'h0, 10'($urandom()), 0, tv);
    send_word(1, 16'h0, 16'h0, 10'd1023, 0, tv);

    write_reg(CFG_SHOTS, 24'hFFFFFF);
    write_reg(CFG_BINS_IN_USE, 24'd3);
    for (int i = 0; i < 9; i++) send_word(0, rand_sample(), rand_sample(), 10'd0, 0, tv);

    // random phases
    hold_req = 1;
    while (words_sent < 1700) begin
      nb = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      write_reg(CFG_BINS_IN_USE, 24'(nb));
      write_reg(CFG_REF_BIN, 24'($urandom_range(0, nb > 0 ? nb : 1)));
      write_reg(CFG_SHOTS, 24'($urandom_range(0, 3)));
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      nitems = $urandom_range(20, 60);
      for (int i = 0; i < nitems; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_word(1, 16'($urandom()), 16'($urandom()),
                    10'($urandom_range(0, nb > 0 ? nb : 1)), 0, tv);
        else
          send_word(0, rand_sample(), rand_sample(), 10'($urandom()), 0, tv);
      end
    end
    s_tvalid <= 0;
    drain();

    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
